FILE: hw/rtl/sec_pkg.sv
`default_nettype none

package sec_pkg;

  // Field widths fixed by the port definition
  localparam int LEVEL_W    = 4;
  localparam int COUNT_W    = 19;
  localparam int TOL_W      = 16;
  localparam int MLEN_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b1;

  localparam logic [MLEN_W-1:0] MATCH_LEN_RESET = 4'd2;
  localparam logic [TOL_W-1:0]  TOLERANCE_RESET = 16'd0;

  // Control that travels with one pair compare down the match pipeline
  typedef struct packed {
    logic valid;
    logic first_row;
    logic final_pair;
  } sec_issue_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sec_match_unit.sv
`default_nettype none

module sec_match_unit #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int LEVELS      = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire sec_pkg::sec_issue_t                      issue,
  input  wire logic [$clog2(DEPTH)-1:0]                 issue_k,
  input  wire logic signed [SAMPLE_BITS-1:0]            base,
  input  wire logic signed [SAMPLE_BITS-1:0]            sample_q,
  input  wire logic [sec_pkg::TOL_W-1:0]                tolerance,
  input  wire logic                                     clear,
  input  wire logic [(LEVELS > 1 ? $clog2(LEVELS) : 1)-1:0] read_level,
  output logic [sec_pkg::COUNT_W-1:0]                   count_a,
  output logic [sec_pkg::COUNT_W-1:0]                   count_b,
  output logic                                          busy
);

  localparam int AW     = $clog2(DEPTH);
  localparam int RUN_W  = $clog2(LEVELS + 1);
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int CMP_W  = (DIFF_W > sec_pkg::TOL_W) ? DIFF_W : sec_pkg::TOL_W;

  // Run length per lag, indexed by lag minus one
  logic [RUN_W-1:0] run_mem [DEPTH];
  logic [RUN_W-1:0] run_q;

  sec_pkg::sec_issue_t s1;
  logic [AW-1:0]       s1_k;

  sec_pkg::sec_issue_t s2;
  logic [AW-1:0]       s2_k;
  logic [DIFF_W-1:0]   s2_abs;
  logic [RUN_W-1:0]    s2_run;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        abs_diff;
  logic                     match;
  logic [RUN_W-1:0]         run_next;

  logic [sec_pkg::COUNT_W-1:0] cnt_a [LEVELS];
  logic [sec_pkg::COUNT_W-1:0] cnt_b [LEVELS];

  // Stage 1: absolute difference against the row base
  always_comb begin
    diff     = DIFF_W'(sample_q) - DIFF_W'(base);
    abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  // Stage 2: threshold, run update (saturating at the level count)
  always_comb begin
    match = CMP_W'(s2_abs) < CMP_W'(tolerance);
    if (!match) begin
      run_next = '0;
    end else if (s2_run == RUN_W'(LEVELS)) begin
      run_next = s2_run;
    end else begin
      run_next = s2_run + RUN_W'(1);
    end
  end

  // Run store: read at issue, write back from stage 2
  always_ff @(posedge clk) begin
    if (issue.valid) begin
      run_q <= run_mem[issue_k];
    end
    if (s2.valid) begin
      run_mem[s2_k] <= run_next;
    end
  end

  // Advance the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else begin
      s1       <= issue;
      s1_k     <= issue_k;
      s2       <= s1;
      s2_k     <= s1_k;
      s2_abs   <= abs_diff;
      s2_run   <= s1.first_row ? '0 : run_q;
    end
  end

  // Count every level below the new run length
  always_ff @(posedge clk) begin
    for (int m = 0; m < LEVELS; m++) begin
      if (clear) begin
        cnt_a[m] <= '0;
        cnt_b[m] <= '0;
      end else if (s2.valid && match && (run_next > RUN_W'(m))) begin
        cnt_a[m] <= cnt_a[m] + sec_pkg::COUNT_W'(1);
        if (!s2.final_pair) begin
          cnt_b[m] <= cnt_b[m] + sec_pkg::COUNT_W'(1);
        end
      end
    end
  end

  assign count_a = cnt_a[read_level];
  assign count_b = cnt_b[read_level];
  assign busy    = s1.valid | s2.valid;

endmodule

`default_nettype wire

FILE: hw/rtl/sample_entropy_match_counter.sv
// Sample entropy match counter. Load a series one word per cycle on the
// item channel; the word with last_sample set closes the series and
// starts the pair scan, during which item_ready stays low. Up to
// MAX_SAMPLES samples are held; later ones, the marked word included, are
// dropped. The scan walks every pair i<j through one shared subtract, compare
// and run-update pipeline fed from a single-port sample memory, one pair per
// scan cycle, with the S_BASE and S_LOAD states before each row to load the
// row base; then one result word per level 0..min(match_len, NLEV-1)
// is offered with count_a and count_b, last_level on
// the final one. The pair total, the ratio and the logarithm are left to
// software.
`default_nettype none

module sample_entropy_match_counter #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_LEVELS  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [sec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sec_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                item_valid,
  output logic                                     item_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]       sample,
  input  wire logic                                last_sample,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output logic [sec_pkg::LEVEL_W-1:0]              level,
  output logic [sec_pkg::COUNT_W-1:0]              count_a,
  output logic [sec_pkg::COUNT_W-1:0]              count_b,
  output logic                                     last_level
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int NLEV  = (MAX_LEVELS < (1 << sec_pkg::LEVEL_W)) ?
                         MAX_LEVELS : (1 << sec_pkg::LEVEL_W);
  localparam int IDX_W = (NLEV > 1) ? $clog2(NLEV) : 1;
  localparam logic [sec_pkg::LEVEL_W-1:0] TOP_MAX = sec_pkg::LEVEL_W'(NLEV - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state;

  logic [sec_pkg::MLEN_W-1:0] match_len;
  logic [sec_pkg::TOL_W-1:0]  tolerance;

  logic [CNT_W-1:0]           count;
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              i;
  logic [AW-1:0]              j;
  logic [AW-1:0]              k;
  logic signed [SAMPLE_BITS-1:0] base;
  logic [sec_pkg::LEVEL_W-1:0] lvl;
  logic [sec_pkg::LEVEL_W-1:0] top_lvl;

  logic signed [SAMPLE_BITS-1:0] samp_mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] samp_q;

  logic                item_acc;
  logic                store_en;
  logic [CNT_W-1:0]    count_stored;
  logic [CNT_W-1:0]    n_minus1;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                busy;
  sec_pkg::sec_issue_t issue;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_len <= sec_pkg::MATCH_LEN_RESET;
      tolerance <= sec_pkg::TOLERANCE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sec_pkg::REG_MATCH_LEN: match_len <= cfg_data[sec_pkg::MLEN_W-1:0];
        sec_pkg::REG_TOLERANCE: tolerance <= cfg_data[sec_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item_acc     = item_valid && item_ready;
    store_en     = item_acc && (count < CNT_W'(MAX_SAMPLES));
    count_stored = store_en ? count + CNT_W'(1) : count;
    n_minus1     = count_stored - CNT_W'(1);
    rd_en        = (state == S_BASE) || (state == S_SCAN);
    rd_addr      = (state == S_BASE) ? i : j;
  end

  // Sample store: write while loading, read during the scan
  always_ff @(posedge clk) begin
    if (store_en) begin
      samp_mem[count[AW-1:0]] <= sample;
    end
    if (rd_en) begin
      samp_q <= samp_mem[rd_addr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      lvl   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            if (last_sample) begin
              count    <= '0;
              lvl      <= '0;
              top_lvl  <= (match_len > TOP_MAX) ? TOP_MAX : match_len;
              i        <= '0;
              last_idx <= n_minus1[AW-1:0];
              state    <= (count_stored < CNT_W'(2)) ? S_EMIT : S_BASE;
            end else begin
              count <= count_stored;
            end
          end
        end
        S_BASE: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          base  <= samp_q;
          j     <= i + AW'(1);
          k     <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (j == last_idx) begin
            if ((i + AW'(1)) == last_idx) begin
              state <= S_DRAIN;
            end else begin
              i     <= i + AW'(1);
              state <= S_BASE;
            end
          end else begin
            j <= j + AW'(1);
            k <= k + AW'(1);
          end
        end
        S_DRAIN: begin
          if (!busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (result_ready) begin
            if (lvl == top_lvl) begin
              state <= S_IDLE;
            end else begin
              lvl <= lvl + sec_pkg::LEVEL_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Issue one pair per scan cycle
  always_comb begin
    issue.valid      = (state == S_SCAN);
    issue.first_row  = (i == '0);
    issue.final_pair = (j == last_idx);
  end

  sec_match_unit #(
    .DEPTH       (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEVELS      (NLEV)
  ) u_match (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .issue_k    (k),
    .base       (base),
    .sample_q   (samp_q),
    .tolerance  (tolerance),
    .clear      (item_acc && last_sample),
    .read_level (lvl[IDX_W-1:0]),
    .count_a    (count_a),
    .count_b    (count_b),
    .busy       (busy)
  );

  assign item_ready   = (state == S_IDLE);
  assign result_valid = (state == S_EMIT);
  assign level        = lvl;
  assign last_level   = (lvl == top_lvl);

`ifndef SYNTHESIS
  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (j == i + k + AW'(1)))
    else $error("scan index out of step");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ((j <= last_idx) && (i < last_idx)))
    else $error("scan past last sample");

  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> !busy)
    else $error("result offered while pairs in flight");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && last_level) |=> (item_ready && (count == '0)))
    else $error("not idle after last level");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store");
`endif

endmodule

`default_nettype wire
